>>> rtl/ecpa_pkg.sv
package ecpa_pkg;

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CURVE_A = 1'b0;
  localparam cfg_idx_t CFG_PRIME   = 1'b1;

  localparam int unsigned PRIME_RESET = 65521;

endpackage

>>> rtl/ecc_point_add_prime_field_top.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_stall    | in_first_x, in_first_y, in_second_x, in_second_y
// out      | out_valid / out_stall  | out_sum_x, out_sum_y, out_slope, out_at_infinity
// cfg      | cfg_we (write only)    | cfg_addr, cfg_wdata
//
// One shared bit-serial unit does every modular multiply and every division
// step, one multiplier or dividend bit at a time.
// in_stall is high from the accepting edge until the result sits in the
// output register; rst_n is synchronous, clears control, zeroes curve_a and
// loads prime with PRIME_RESET.
module ecc_point_add_prime_field_top #(
  parameter int FIELD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  ecpa_pkg::cfg_idx_t    cfg_addr,
  input  logic [FIELD_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FIELD_BITS-1:0] in_first_x,
  input  logic [FIELD_BITS-1:0] in_first_y,
  input  logic [FIELD_BITS-1:0] in_second_x,
  input  logic [FIELD_BITS-1:0] in_second_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_BITS-1:0] out_sum_x,
  output logic [FIELD_BITS-1:0] out_sum_y,
  output logic [FIELD_BITS-1:0] out_slope,
  output logic                  out_at_infinity
);

  localparam int W  = FIELD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] PRIME_RST = W'(ecpa_pkg::PRIME_RESET);
  localparam logic [W-1:0] ONE = W'(1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL    = 5'd1;
  localparam logic [4:0] S_DIV    = 5'd2;
  localparam logic [4:0] S_RED    = 5'd3;
  localparam logic [4:0] S_RED_WB = 5'd4;
  localparam logic [4:0] S_CMP    = 5'd5;
  localparam logic [4:0] S_DBL1   = 5'd6;
  localparam logic [4:0] S_DBL2   = 5'd7;
  localparam logic [4:0] S_DBL3   = 5'd8;
  localparam logic [4:0] S_INV0   = 5'd9;
  localparam logic [4:0] S_LOOP   = 5'd10;
  localparam logic [4:0] S_INV_Q  = 5'd11;
  localparam logic [4:0] S_INV_T  = 5'd12;
  localparam logic [4:0] S_SLOPE  = 5'd13;
  localparam logic [4:0] S_SQ     = 5'd14;
  localparam logic [4:0] S_X1     = 5'd15;
  localparam logic [4:0] S_X2     = 5'd16;
  localparam logic [4:0] S_Y1     = 5'd17;
  localparam logic [4:0] S_Y2     = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  logic [W-1:0] curve_a_r, prime_r;
  logic [4:0]   state_r, ret_r;
  logic [2:0]   idx_r;
  logic [W-1:0] crd_r [0:4];   // x1, y1, x2, y2, a
  logic [W-1:0] num_r, den_r, tmp_r, r0_r, r1_r, t0_r, t1_r, s_r, x3_r;
  logic [W-1:0] u_a_r, u_b_r;
  logic [W:0]   u_c_r;
  logic [CW-1:0] cnt_r;
  logic         inf_r;

  logic [W:0]   div_sh;
  logic         div_ge;
  logic [W-1:0] q_fix;

  function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
    logic [W-1:0] d;
    d = x - y;
    if (x < y) begin
      d = d + m;
    end
    return d;
  endfunction

  assign div_sh = {u_c_r[W-1:0], u_b_r[W-1]};
  assign div_ge = div_sh >= {1'b0, u_a_r};
  assign q_fix  = (u_b_r >= prime_r) ? u_b_r - prime_r : u_b_r;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r <= '0;
      prime_r   <= PRIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ecpa_pkg::CFG_CURVE_A: curve_a_r <= cfg_wdata;
        ecpa_pkg::CFG_PRIME:   prime_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      out_valid <= 1'b0;
      inf_r     <= 1'b0;
      idx_r     <= '0;
      cnt_r     <= '0;
    end else begin
      if (out_valid && !out_stall && state_r != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            crd_r[0] <= in_first_x;
            crd_r[1] <= in_first_y;
            crd_r[2] <= in_second_x;
            crd_r[3] <= in_second_y;
            crd_r[4] <= curve_a_r;
            idx_r    <= '0;
            inf_r    <= (prime_r < W'(2));
            state_r  <= (prime_r < W'(2)) ? S_OUT : S_RED;
          end
        end
        S_MUL: begin
          if (u_b_r == '0) begin
            state_r <= ret_r;
          end else begin
            if (u_b_r[0]) begin
              u_c_r <= {1'b0, add_m(u_c_r[W-1:0], u_a_r, prime_r)};
            end
            u_a_r <= add_m(u_a_r, u_a_r, prime_r);
            u_b_r <= u_b_r >> 1;
          end
        end
        S_DIV: begin
          u_c_r <= div_ge ? div_sh - {1'b0, u_a_r} : div_sh;
          u_b_r <= {u_b_r[W-2:0], div_ge};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(W - 1)) begin
            state_r <= ret_r;
          end
        end
        S_RED: begin
          u_a_r   <= prime_r;
          u_b_r   <= crd_r[idx_r];
          u_c_r   <= '0;
          cnt_r   <= '0;
          ret_r   <= S_RED_WB;
          state_r <= S_DIV;
        end
        S_RED_WB: begin
          crd_r[idx_r] <= u_c_r[W-1:0];
          idx_r        <= idx_r + 3'd1;
          state_r      <= (idx_r == 3'd4) ? S_CMP : S_RED;
        end
        S_CMP: begin
          if (crd_r[0] == crd_r[2] && crd_r[1] == crd_r[3]) begin
            u_a_r   <= crd_r[0];
            u_b_r   <= crd_r[0];
            u_c_r   <= '0;
            ret_r   <= S_DBL1;
            state_r <= S_MUL;
          end else begin
            num_r   <= sub_m(crd_r[3], crd_r[1], prime_r);
            den_r   <= sub_m(crd_r[2], crd_r[0], prime_r);
            state_r <= S_INV0;
          end
        end
        S_DBL1: begin
          tmp_r   <= u_c_r[W-1:0];
          num_r   <= add_m(u_c_r[W-1:0], u_c_r[W-1:0], prime_r);
          state_r <= S_DBL2;
        end
        S_DBL2: begin
          num_r   <= add_m(num_r, tmp_r, prime_r);
          state_r <= S_DBL3;
        end
        S_DBL3: begin
          num_r   <= add_m(num_r, crd_r[4], prime_r);
          den_r   <= add_m(crd_r[1], crd_r[1], prime_r);
          state_r <= S_INV0;
        end
        S_INV0: begin
          r0_r <= prime_r;
          r1_r <= den_r;
          t0_r <= '0;
          t1_r <= ONE;
          if (den_r == '0) begin
            inf_r   <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (r1_r == '0) begin
            if (r0_r != ONE) begin
              inf_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              state_r <= S_SLOPE;
            end
          end else begin
            u_a_r   <= r1_r;
            u_b_r   <= r0_r;
            u_c_r   <= '0;
            cnt_r   <= '0;
            ret_r   <= S_INV_Q;
            state_r <= S_DIV;
          end
        end
        S_INV_Q: begin
          r0_r    <= r1_r;
          r1_r    <= u_c_r[W-1:0];
          u_a_r   <= q_fix;
          u_b_r   <= t1_r;
          u_c_r   <= '0;
          ret_r   <= S_INV_T;
          state_r <= S_MUL;
        end
        S_INV_T: begin
          t0_r    <= t1_r;
          t1_r    <= sub_m(t0_r, u_c_r[W-1:0], prime_r);
          state_r <= S_LOOP;
        end
        S_SLOPE: begin
          u_a_r   <= num_r;
          u_b_r   <= t0_r;
          u_c_r   <= '0;
          ret_r   <= S_SQ;
          state_r <= S_MUL;
        end
        S_SQ: begin
          s_r     <= u_c_r[W-1:0];
          u_a_r   <= u_c_r[W-1:0];
          u_b_r   <= u_c_r[W-1:0];
          u_c_r   <= '0;
          ret_r   <= S_X1;
          state_r <= S_MUL;
        end
        S_X1: begin
          x3_r    <= sub_m(u_c_r[W-1:0], crd_r[0], prime_r);
          state_r <= S_X2;
        end
        S_X2: begin
          x3_r    <= sub_m(x3_r, crd_r[2], prime_r);
          state_r <= S_Y1;
        end
        S_Y1: begin
          u_a_r   <= s_r;
          u_b_r   <= sub_m(crd_r[0], x3_r, prime_r);
          u_c_r   <= '0;
          ret_r   <= S_Y2;
          state_r <= S_MUL;
        end
        S_Y2: begin
          tmp_r   <= sub_m(u_c_r[W-1:0], crd_r[1], prime_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the previous transfer has left the output register
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            out_at_infinity <= inf_r;
            out_sum_x       <= inf_r ? '0 : x3_r;
            out_sum_y       <= inf_r ? '0 : tmp_r;
            out_slope       <= inf_r ? '0 : s_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_infinity |-> out_sum_x == '0 && out_sum_y == '0 && out_slope == '0)
    else $error("point at infinity with nonzero coordinates");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("sequencer idle after input transfer");

  a_coef_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOP |-> t0_r < prime_r && t1_r < prime_r)
    else $error("Euclid coefficient not reduced");

  a_remainder_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INV_Q |-> u_c_r[W-1:0] < r1_r)
    else $error("Euclid remainder did not shrink");
`endif

endmodule
